### sv/fir_lp_pkg.sv
// ============================================================================
// fir_lp_pkg
// Shared constants and the coefficient ROM for the 49-tap low-pass FIR.
// ============================================================================
package fir_lp_pkg;

    // defaults for the top-level parameters
    localparam int TAPS_DEF        = 49;
    localparam int SAMPLE_BITS_DEF = 16;

    // coefficient format, signed Q1.15
    localparam int COEF_BITS = 16;
    localparam int COEF_FRAC = 15;

    // result field width
    localparam int OUT_BITS = 16;

    // rom geometry
    localparam int ROM_TAPS  = 49;
    localparam int ROM_IDX_W = 6;

    // tap index width covering the largest supported tap count (256)
    localparam int TAP_IDX_W = 8;

    // accumulator guard bits, exact for up to 256 taps
    localparam int ACC_GUARD = 8;

    typedef logic signed [COEF_BITS-1:0] t_coef;

    localparam t_coef COEF_ROM [ROM_TAPS] = '{
        -16'sd528, -16'sd55,  -16'sd42,  -16'sd18,  16'sd19,   16'sd69,
        16'sd133,  16'sd210,  16'sd301,  16'sd405,  16'sd520,  16'sd645,
        16'sd777,  16'sd915,  16'sd1055, 16'sd1194, 16'sd1331, 16'sd1460,
        16'sd1579, 16'sd1686, 16'sd1778, 16'sd1851, 16'sd1905, 16'sd1938,
        16'sd1949, 16'sd1938, 16'sd1905, 16'sd1851, 16'sd1778, 16'sd1686,
        16'sd1579, 16'sd1460, 16'sd1331, 16'sd1194, 16'sd1055, 16'sd915,
        16'sd777,  16'sd645,  16'sd520,  16'sd405,  16'sd301,  16'sd210,
        16'sd133,  16'sd69,   16'sd19,   -16'sd18,  -16'sd42,  -16'sd55,
        -16'sd528
    };

    // taps past the end of the rom have a zero coefficient
    function automatic t_coef coef_at(input logic [TAP_IDX_W-1:0] idx);
        t_coef c;
        if (idx < TAP_IDX_W'(ROM_TAPS)) begin
            c = COEF_ROM[idx[ROM_IDX_W-1:0]];
        end else begin
            c = '0;
        end
        return c;
    endfunction

endpackage

### sv/fir_lowpass_49_tap.sv
// ============================================================================
// fir_lowpass_49_tap
// Direct-form FIR low-pass, one shared multiply-accumulate stepping the taps.
// ============================================================================
// each sample runs through the tap sweep, the read, multiply and accumulate
//   stages and the output register; the input stalls until its sum is loaded,
//   as the single MAC reads one delay-line word per cycle
// a finished result waits in the output register while the next sample runs
// reset (synchronous, active low) clears the write pointer, the fill count and
//   all control; the delay line reads as zero until each slot is written
module fir_lowpass_49_tap
    import fir_lp_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sample request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // filtered request channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [OUT_BITS-1:0]   o_filtered
);

    // ------------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------------
    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;   // slot / tap index
    localparam int FILL_W = $clog2(TAPS + 1);                // 0 .. TAPS
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;         // Q2.30 at default
    localparam int ACC_W  = PROD_W + ACC_GUARD;              // 40 bits at default

    localparam logic [TAP_W-1:0]  LAST_SLOT = TAP_W'(TAPS - 1);
    localparam logic [FILL_W-1:0] FULL      = FILL_W'(TAPS);

    // rounding constant: one half lsb of the Q1.15 result
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
    // saturation bounds of a SAMPLE_BITS-wide signed code
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a sample
    localparam logic [1:0] ST_RUN   = 2'd1;  // issuing one tap read per cycle
    localparam logic [1:0] ST_DRAIN = 2'd2;  // read / multiply / add pipe emptying
    localparam logic [1:0] ST_FIN   = 2'd3;  // sum complete, waiting for output slot

    // ------------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------------
    logic [1:0]              r_state;
    logic [TAP_W-1:0]        r_wp;        // next delay-line slot to write
    logic [FILL_W-1:0]       r_fill;      // slots written since reset
    logic [TAP_W-1:0]        r_tap;       // tap being issued, 0 = newest
    logic [TAP_W-1:0]        r_addr;      // delay-line slot of that tap

    // delay line, at most one write and one read per cycle
    logic [SAMPLE_BITS-1:0]  r_mem [TAPS];

    // read stage
    logic                    r_s1;
    logic                    r_s1_last;
    logic [SAMPLE_BITS-1:0]  r_rd_data;
    logic                    r_rd_live;   // slot was written since reset
    t_coef                   r_rd_coef;

    // multiply stage
    logic                    r_s2;
    logic                    r_s2_last;
    logic signed [PROD_W-1:0] r_prod;

    // accumulator
    logic signed [ACC_W-1:0] r_acc;

    // output register
    logic                    r_out_vld;
    logic signed [OUT_BITS-1:0] r_out;

    // ------------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------------
    logic n_in_acc;
    logic n_out_take;
    logic n_load;

    assign o_stall    = (r_state != ST_IDLE);
    assign n_in_acc   = i_valid && !o_stall;
    assign n_out_take = r_out_vld && !i_stall;
    // the finished sum moves out when the output register is empty or emptying
    assign n_load     = (r_state == ST_FIN) && (!r_out_vld || !i_stall);

    assign o_valid    = r_out_vld;
    assign o_filtered = r_out;

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    logic             n_issue;
    logic             n_issue_last;
    logic [TAP_W-1:0] n_wp_inc;
    logic [TAP_W-1:0] n_addr_dec;

    assign n_issue      = (r_state == ST_RUN);
    assign n_issue_last = n_issue && (r_tap == LAST_SLOT);
    assign n_wp_inc     = (r_wp == LAST_SLOT) ? '0 : r_wp + TAP_W'(1);
    // walking back in time through the circular buffer
    assign n_addr_dec   = (r_addr == '0) ? LAST_SLOT : r_addr - TAP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_tap   <= '0;
            r_addr  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (n_in_acc) begin
                        // newest sample sits at the slot just written
                        r_state <= ST_RUN;
                        r_tap   <= '0;
                        r_addr  <= r_wp;
                        r_wp    <= n_wp_inc;
                        if (r_fill != FULL) begin
                            r_fill <= r_fill + FILL_W'(1);
                        end
                    end
                end
                ST_RUN: begin
                    r_tap  <= r_tap + TAP_W'(1);
                    r_addr <= n_addr_dec;
                    if (n_issue_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_s2 && r_s2_last) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (n_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // delay line: written on the sample request, read once per issued tap
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (n_in_acc) begin
            r_mem[r_wp] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_addr];
    end

    // ------------------------------------------------------------------------
    // read stage: slot liveness and coefficient lookup
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1      <= 1'b0;
            r_s1_last <= 1'b0;
        end else begin
            r_s1      <= n_issue;
            r_s1_last <= n_issue_last;
        end
    end

    always_ff @(posedge i_clk) begin
        // slots not yet written since reset read as zero
        r_rd_live <= (FILL_W'(r_addr) < r_fill);
        r_rd_coef <= coef_at(TAP_IDX_W'(r_tap));
    end

    // ------------------------------------------------------------------------
    // multiply stage
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] n_mul_a;
    logic signed [PROD_W-1:0]      n_prod;

    assign n_mul_a = r_rd_live ? $signed(r_rd_data) : '0;
    assign n_prod  = n_mul_a * r_rd_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2      <= 1'b0;
            r_s2_last <= 1'b0;
        end else begin
            r_s2      <= r_s1;
            r_s2_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // ------------------------------------------------------------------------
    // accumulate stage, cleared on each sample request
    // ------------------------------------------------------------------------
    logic signed [ACC_W-1:0] n_acc;

    assign n_acc = r_acc + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (n_in_acc) begin
            r_acc <= '0;
        end else if (r_s2) begin
            r_acc <= n_acc;
        end
    end

    // ------------------------------------------------------------------------
    // round half up, floor shift, saturate to SAMPLE_BITS
    // ------------------------------------------------------------------------
    logic signed [ACC_W-1:0]   n_round;
    logic signed [ACC_W-1:0]   n_q;
    logic [SAMPLE_BITS-1:0]    n_sat;

    assign n_round = r_acc + ROUND_HALF;
    assign n_q     = n_round >>> COEF_FRAC;

    always_comb begin
        priority if (n_q > SAT_MAX) begin
            n_sat = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (n_q < SAT_MIN) begin
            n_sat = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            n_sat = n_q[SAMPLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (n_load) begin
            r_out_vld <= 1'b1;
        end else if (n_out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out <= OUT_BITS'(n_sat);
        end
    end

endmodule

### sv/fir_lp_chk.sv
// ============================================================================
// fir_lp_chk
// Port-level checks for the FIR low-pass, bound to the top level.
// ============================================================================
module fir_lp_chk #(
    parameter int TAPS        = 49,
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic signed [SAMPLE_BITS-1:0] i_sample,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [15:0]            o_filtered
);

    logic n_in_acc;

    assign n_in_acc = i_valid && !o_stall;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_filtered))
        else $error("stalled filtered request changed or dropped");

    // a sample request closes the input side at once
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_in_acc |=> o_stall)
        else $error("input not stalled after sample request");

    // the input is still closed at a single check point, in the drain after the tap sweep
    a_busy_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_in_acc |-> ##(TAPS + 2) o_stall)
        else $error("input reopened before tap sweep finished");

    // a new result only shows up as a sample finishes
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall) && !o_stall)
        else $error("result appeared with no sample in flight");

endmodule

bind fir_lowpass_49_tap fir_lp_chk #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fir_lp_chk (.*);
